// ===== rtl/core/sbce_pkg.sv =====
// Shared types, codes and constants for the single-byte charset encoder.
`default_nettype none

package sbce_pkg;

    // Default number of 256-entry pages in the byte table
    localparam int MAX_PAGES_DEF = 16;

    // Item commands, carried in the slave-side tuser
    typedef enum logic [1:0] {
        CMD_CLEAR       = 2'd0,
        CMD_LOAD_DECODE = 2'd1,
        CMD_LOAD_EXTRA  = 2'd2,
        CMD_ENCODE      = 2'd3
    } cmd_t;

    // Configuration register indexes
    localparam logic REG_REPLACEMENT = 1'b0;

    // Constants of the mapping
    localparam logic [7:0]  REPL_RESET    = 8'h3F;
    localparam logic [7:0]  DECODE_FLIP   = 8'h80;
    localparam logic [15:0] UNIT_NO_CHAR  = 16'hFFFD;
    localparam logic [5:0]  HIGH_SURR_TAG = 6'b110110;
    localparam logic [5:0]  LOW_SURR_TAG  = 6'b110111;

    // Controller states
    typedef enum logic [2:0] {
        ST_INIT_SWEEP,
        ST_IDLE,
        ST_PAGE,
        ST_SWEEP,
        ST_ENTRY,
        ST_RESOLVE,
        ST_OUT_FIRST,
        ST_OUT_SECOND
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic clear_state;
        logic sweep_step;
        logic load_commit;
        logic resolve;
        logic out_load;
        logic out_sel;
    } ctrl_cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        cmd_t command;
        logic sweep_done;
        logic resolve_emits;
        logic res_two;
        logic out_free;
    } dp_status_t;

endpackage : sbce_pkg

`default_nettype wire

// ===== rtl/core/sbce_datapath.sv =====
// Datapath: item registers, page index and byte table memories, result slots, output register.
`default_nettype none

module sbce_datapath #(
    parameter int MAX_PAGES = sbce_pkg::MAX_PAGES_DEF
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire sbce_pkg::ctrl_cmd_t  cmd,
    output sbce_pkg::dp_status_t      status,
    input  wire logic [1:0]           in_command,
    input  wire logic [7:0]           in_byte_value,
    input  wire logic [15:0]          in_code_unit,
    input  wire logic                 in_end_of_text,
    input  wire logic [7:0]           replacement_byte,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [15:0]               m_tdata,
    output logic [0:0]                m_tuser,
    output logic                      m_tlast
);

    localparam int DEPTH  = MAX_PAGES * 256;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W  = $clog2(MAX_PAGES + 1);

    // Item registers
    sbce_pkg::cmd_t item_cmd_reg;
    logic [7:0]     item_bv_reg;
    logic [15:0]    item_cu_reg;
    logic           item_eot_reg;

    // Table state
    logic [PAGE_W-1:0] page_mem [256];
    logic [8:0]        byte_mem [DEPTH];
    logic [255:0]      page_valid_reg;
    logic [PAGE_W-1:0] pidx_q;
    logic              pvalid_q;
    logic [8:0]        ent_q;
    logic [CNT_W-1:0]  pages_used_reg;
    logic              full_reg;
    logic              pending_reg;
    logic [ADDR_W-1:0] sweep_cnt_reg;

    // Result slots
    logic [7:0] res0_byte_reg;
    logic       res0_unm_reg;
    logic [7:0] res1_byte_reg;
    logic       res1_unm_reg;
    logic       res_two_reg;

    // Output register
    logic        out_valid_reg;
    logic [7:0]  out_byte_reg;
    logic        out_unm_reg;
    logic        out_full_reg;
    logic        out_last_reg;

    // Load decision
    logic [7:0]        load_byte;
    logic              load_skip;
    logic              have_room;
    logic              load_write;
    logic              load_alloc;
    logic              load_drop;
    logic [PAGE_W-1:0] page_sel;
    logic [7:0]        hi_byte;
    logic [7:0]        lo_byte;

    // Memory write port
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    logic [8:0]        mem_wdata;
    logic [ADDR_W-1:0] ent_raddr;

    // Resolve logic
    logic       mapped;
    logic       is_high;
    logic       is_low;
    logic       norm_emits;
    logic [7:0] norm_byte;
    logic       norm_unm;
    logic       pend_hold;
    logic       emits;

    assign hi_byte = item_cu_reg[15:8];
    assign lo_byte = item_cu_reg[7:0];

    // Capture the request fields
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            item_cmd_reg <= sbce_pkg::cmd_t'(in_command);
            item_bv_reg  <= in_byte_value;
            item_cu_reg  <= in_code_unit;
            item_eot_reg <= in_end_of_text;
        end
    end

    // Decide what a load does with its entry
    always_comb
    begin
        load_byte  = (item_cmd_reg == sbce_pkg::CMD_LOAD_DECODE) ?
                     (item_bv_reg ^ sbce_pkg::DECODE_FLIP) : item_bv_reg;
        load_skip  = (item_cmd_reg == sbce_pkg::CMD_LOAD_DECODE) &&
                     (item_cu_reg == sbce_pkg::UNIT_NO_CHAR);
        have_room  = pages_used_reg < CNT_W'(MAX_PAGES);
        load_write = !load_skip && (pvalid_q || have_room);
        load_alloc = !load_skip && !pvalid_q && have_room;
        load_drop  = !load_skip && !pvalid_q && !have_room;
        page_sel   = pvalid_q ? pidx_q : PAGE_W'(pages_used_reg);
    end

    // Page index memory with registered read
    always_ff @(posedge clk)
    begin
        if (cmd.load_commit && load_alloc)
            page_mem[hi_byte] <= PAGE_W'(pages_used_reg);
        pidx_q <= page_mem[hi_byte];
    end

    // Page valid bits, page count, full flag, held surrogate
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            page_valid_reg <= '0;
            pvalid_q       <= 1'b0;
            pages_used_reg <= '0;
            full_reg       <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            pvalid_q <= page_valid_reg[hi_byte];
            if (cmd.clear_state)
            begin
                page_valid_reg <= '0;
                pages_used_reg <= '0;
                full_reg       <= 1'b0;
                pending_reg    <= 1'b0;
            end
            else if (cmd.load_commit)
            begin
                if (load_alloc)
                begin
                    page_valid_reg[hi_byte] <= 1'b1;
                    pages_used_reg          <= pages_used_reg + 1'b1;
                end
                if (load_drop)
                    full_reg <= 1'b1;
            end
            else if (cmd.resolve)
            begin
                pending_reg <= pend_hold;
            end
        end
    end

    // Sweep counter for the clearing pass
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sweep_cnt_reg <= '0;
        else if (cmd.sweep_step)
            sweep_cnt_reg <= status.sweep_done ? '0 : sweep_cnt_reg + 1'b1;
    end

    // Select the byte table write
    always_comb
    begin
        ent_raddr = ADDR_W'({pidx_q, lo_byte});
        if (cmd.sweep_step)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_cnt_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = cmd.load_commit && load_write;
            mem_waddr = ADDR_W'({page_sel, lo_byte});
            mem_wdata = {1'b1, load_byte};
        end
    end

    // Byte table memory with registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
            byte_mem[mem_waddr] <= mem_wdata;
        ent_q <= byte_mem[ent_raddr];
    end

    // Work out the results of an encode
    always_comb
    begin
        mapped  = pvalid_q && ent_q[8];
        is_high = item_cu_reg[15:10] == sbce_pkg::HIGH_SURR_TAG;
        is_low  = item_cu_reg[15:10] == sbce_pkg::LOW_SURR_TAG;
        norm_byte  = mapped ? ent_q[7:0] : replacement_byte;
        norm_unm   = !mapped;
        norm_emits = mapped || !is_high || item_eot_reg;
        if (pending_reg)
        begin
            pend_hold = !is_low && !norm_emits;
            emits     = 1'b1;
        end
        else
        begin
            pend_hold = !norm_emits;
            emits     = norm_emits;
        end
    end

    // Fill the result slots
    always_ff @(posedge clk)
    begin
        if (cmd.resolve)
        begin
            if (pending_reg)
            begin
                res0_byte_reg <= replacement_byte;
                res0_unm_reg  <= 1'b1;
                res1_byte_reg <= norm_byte;
                res1_unm_reg  <= norm_unm;
                res_two_reg   <= !is_low && norm_emits;
            end
            else
            begin
                res0_byte_reg <= norm_byte;
                res0_unm_reg  <= norm_unm;
                res1_byte_reg <= norm_byte;
                res1_unm_reg  <= norm_unm;
                res_two_reg   <= 1'b0;
            end
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_full_reg <= full_reg;
            if (item_cmd_reg != sbce_pkg::CMD_ENCODE)
            begin
                out_byte_reg <= '0;
                out_unm_reg  <= 1'b0;
                out_last_reg <= 1'b1;
            end
            else
            begin
                out_byte_reg <= cmd.out_sel ? res1_byte_reg : res0_byte_reg;
                out_unm_reg  <= cmd.out_sel ? res1_unm_reg : res0_unm_reg;
                out_last_reg <= cmd.out_sel || !res_two_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_full_reg, out_byte_reg};
    assign m_tuser  = out_unm_reg;
    assign m_tlast  = out_last_reg;

    // Status to the controller
    assign status.command       = item_cmd_reg;
    assign status.sweep_done    = sweep_cnt_reg == ADDR_W'(DEPTH - 1);
    assign status.resolve_emits = emits;
    assign status.res_two       = res_two_reg;
    assign status.out_free      = !out_valid_reg || m_tready;

endmodule : sbce_datapath

`default_nettype wire

// ===== rtl/core/sbce_ctrl.sv =====
// Controller: sequences clearing passes, table lookups, loads and result delivery.
`default_nettype none

module sbce_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire sbce_pkg::dp_status_t  status,
    output sbce_pkg::ctrl_cmd_t        cmd
);

    sbce_pkg::state_t state_reg;
    sbce_pkg::state_t state_next;

    // Hold the state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= sbce_pkg::ST_INIT_SWEEP;
        else
            state_reg <= state_next;
    end

    // Advance the state and issue datapath commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            sbce_pkg::ST_INIT_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_done)
                    state_next = sbce_pkg::ST_IDLE;
            end
            sbce_pkg::ST_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
                if (s_tvalid)
                    state_next = sbce_pkg::ST_PAGE;
            end
            sbce_pkg::ST_PAGE:
            begin
                if (status.command == sbce_pkg::CMD_CLEAR)
                begin
                    cmd.clear_state = 1'b1;
                    state_next      = sbce_pkg::ST_SWEEP;
                end
                else
                begin
                    state_next = sbce_pkg::ST_ENTRY;
                end
            end
            sbce_pkg::ST_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (status.sweep_done)
                    state_next = sbce_pkg::ST_OUT_FIRST;
            end
            sbce_pkg::ST_ENTRY:
            begin
                if (status.command == sbce_pkg::CMD_ENCODE)
                begin
                    state_next = sbce_pkg::ST_RESOLVE;
                end
                else
                begin
                    cmd.load_commit = 1'b1;
                    state_next      = sbce_pkg::ST_OUT_FIRST;
                end
            end
            sbce_pkg::ST_RESOLVE:
            begin
                cmd.resolve = 1'b1;
                state_next  = status.resolve_emits ? sbce_pkg::ST_OUT_FIRST
                                                   : sbce_pkg::ST_IDLE;
            end
            sbce_pkg::ST_OUT_FIRST:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    if (status.command == sbce_pkg::CMD_ENCODE && status.res_two)
                        state_next = sbce_pkg::ST_OUT_SECOND;
                    else
                        state_next = sbce_pkg::ST_IDLE;
                end
            end
            sbce_pkg::ST_OUT_SECOND:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = 1'b1;
                    state_next   = sbce_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sbce_pkg::ST_IDLE;
            end
        endcase
    end

endmodule : sbce_ctrl

`default_nettype wire

// ===== rtl/core/single_byte_charset_encoder.sv =====
// Top level of the single-byte charset encoder: register port, controller and datapath.
//
// Use: load a map from UTF-16 code units to bytes, then stream code units through it.
// Slave channel s_*: one request per item; tuser = command, tlast = end of text,
// tdata = byte value and code unit. Master channel m_*: result items; tdata = byte and
// table-full flag, tuser = unmappable, tlast = final result of the request.
// The APB port holds the replacement byte at address 0; write it only while idle.
// A request is taken only in the idle state. A load reads the page index and then commits
// its entry to the byte table; an encode reads the page index, then the byte table, then
// works out its result or results, one step after another. A clear sweeps the whole byte
// table before its result. An encode that holds a high surrogate gives no result and
// returns to idle. At reset the byte table is swept, one entry a cycle, over all
// MAX_PAGES*256 entries (4096 by default) with s_tready low; configuration writes are
// still taken. When the receiver stalls, the finished result waits in the output
// register and the next request is still accepted; the second result of a pair waits
// for room.
`default_nettype none

module single_byte_charset_encoder #(
    parameter int MAX_PAGES = sbce_pkg::MAX_PAGES_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // Input requests
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // [7:0] byte_value, [23:8] code_unit
    input  wire logic [1:0]  s_tuser,   // [1:0] command
    input  wire logic        s_tlast,   // end_of_text
    // Results
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] out_byte, [8] table_full, [15:9] zero
    output logic [0:0]       m_tuser,   // [0] unmappable
    output logic             m_tlast,   // last
    // Register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0]           repl_reg;
    logic                 reg_index;
    sbce_pkg::ctrl_cmd_t  ctrl_cmd;
    sbce_pkg::dp_status_t dp_status;

    assign reg_index = paddr[2];
    assign pready    = 1'b1;

    // Write the replacement byte register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            repl_reg <= sbce_pkg::REPL_RESET;
        else if (psel && penable && pwrite && pready &&
                 reg_index == sbce_pkg::REG_REPLACEMENT)
            repl_reg <= pwdata[7:0];
    end

    // Read back the register
    always_comb
    begin
        if (reg_index == sbce_pkg::REG_REPLACEMENT)
            prdata = {24'd0, repl_reg};
        else
            prdata = '0;
    end

    sbce_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (dp_status),
        .cmd      (ctrl_cmd)
    );

    sbce_datapath #(
        .MAX_PAGES (MAX_PAGES)
    ) u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (ctrl_cmd),
        .status           (dp_status),
        .in_command       (s_tuser),
        .in_byte_value    (s_tdata[7:0]),
        .in_code_unit     (s_tdata[23:8]),
        .in_end_of_text   (s_tlast),
        .replacement_byte (repl_reg),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_tdata          (m_tdata),
        .m_tuser          (m_tuser),
        .m_tlast          (m_tlast)
    );

endmodule : single_byte_charset_encoder

`default_nettype wire

// ===== verif/single_byte_charset_encoder_tb.sv =====
// Testbench for the single-byte charset encoder: table build, encode stream, replacement register.
`timescale 1ns / 1ps

module single_byte_charset_encoder_tb;

    localparam int PAGES         = sbce_pkg::MAX_PAGES_DEF;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 16;
    localparam int LONG_HOLD     = 400;
    localparam int RANDOM_ITEMS  = 1400;
    localparam int KNOWN_DEPTH   = 64;
    localparam int DIRECTED_ROWS = 24;
    localparam int POOL_SIZE     = 12;

    typedef struct packed {
        logic [7:0] code_byte;
        logic       unmapped;
        logic       full;
        logic       last;
    } enc_result_t;

    typedef struct packed {
        sbce_pkg::cmd_t cmd;
        logic [7:0]     bval;
        logic [15:0]    unit;
        logic           eot;
        logic           typed;
        enc_result_t    res;
    } stim_row_t;

    localparam enc_result_t RES_NONE   = '0;
    localparam enc_result_t RES_STATUS = '{8'h00, 1'b0, 1'b0, 1'b1};
    localparam enc_result_t RES_REPL   = '{sbce_pkg::REPL_RESET, 1'b1, 1'b0, 1'b1};

    // High bytes that most load requests draw from; surrogate pages among them
    localparam logic [7:0] HIGH_POOL [POOL_SIZE] = '{8'h00, 8'h01, 8'h03, 8'h04, 8'h20, 8'h25,
                                                     8'hD8, 8'hDB, 8'hDC, 8'hDF, 8'hFE, 8'hFF};

    // Directed requests; all go through the predictor, and typed rows carry their own first result
    localparam stim_row_t DIRECTED_PLAN [DIRECTED_ROWS] = '{
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'h0041, 1'b1, 1'b1, RES_REPL},   // unmapped
        '{sbce_pkg::CMD_LOAD_DECODE, 8'hC1, 16'h0041, 1'b0, 1'b1, RES_STATUS},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'h0041, 1'b1, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_LOAD_DECODE, 8'h00, 16'hFFFD, 1'b0, 1'b1, RES_STATUS}, // skipped
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hFFFD, 1'b0, 1'b1, RES_REPL},
        '{sbce_pkg::CMD_LOAD_EXTRA,  8'hFF, 16'hFFFF, 1'b0, 1'b1, RES_STATUS},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hFFFF, 1'b1, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_LOAD_EXTRA,  8'h00, 16'h0000, 1'b0, 1'b1, RES_STATUS},
        '{sbce_pkg::CMD_ENCODE,      8'hFF, 16'h0000, 1'b0, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hD800, 1'b0, 1'b0, RES_NONE},   // held
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hDC00, 1'b0, 1'b0, RES_NONE},   // absorbed
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hDBFF, 1'b0, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'h0041, 1'b0, 1'b0, RES_NONE},   // flush, own
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hD912, 1'b0, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hDA00, 1'b0, 1'b0, RES_NONE},   // hold again
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hDFFF, 1'b1, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hD800, 1'b1, 1'b1, RES_REPL},   // no hold
        '{sbce_pkg::CMD_LOAD_EXTRA,  8'h55, 16'hD805, 1'b0, 1'b1, RES_STATUS},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hD805, 1'b0, 1'b0, RES_NONE},   // mapped
        '{sbce_pkg::CMD_LOAD_DECODE, 8'h12, 16'h0041, 1'b0, 1'b1, RES_STATUS}, // overwrite
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'h0041, 1'b0, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'hDB00, 1'b0, 1'b0, RES_NONE},
        '{sbce_pkg::CMD_CLEAR,       8'h00, 16'h0000, 1'b0, 1'b1, RES_STATUS}, // drop held
        '{sbce_pkg::CMD_ENCODE,      8'h00, 16'h0041, 1'b1, 1'b1, RES_REPL}
    };

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [7:0] byte_value, [23:8] code_unit
    logic [1:0]  s_tuser;   // [1:0] command
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [7:0] out_byte, [8] table_full, [15:9] zero
    logic [0:0]  m_tuser;   // [0] unmappable
    logic        m_tlast;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    // Predicted table state
    logic        page_ok   [256];
    logic [4:0]  page_no   [256];
    logic        entry_ok  [PAGES*256];
    logic [7:0]  entry_val [PAGES*256];
    int          pages_taken;
    logic        high_held;
    logic        full_seen;
    logic [7:0]  repl_byte;

    enc_result_t expected_results [$];
    logic [15:0] mapped_units [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_asks;
    int items_sent;
    int mismatch_count;

    single_byte_charset_encoder #(.MAX_PAGES(PAGES)) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        $display("ERROR %s: got %0h, expected %0h at %0t", what, got, want, $time);
    endtask

    function automatic void clear_tables();
        foreach (page_ok[i]) page_ok[i] = 1'b0;
        foreach (entry_ok[i]) entry_ok[i] = 1'b0;
        pages_taken = 0;
        high_held   = 1'b0;
        full_seen   = 1'b0;
    endfunction

    // Take a page for a new high byte, or drop the entry when none is left
    function automatic void map_unit(input logic [15:0] unit, input logic [7:0] value);
        logic [7:0] hi;
        int         slot;
        hi = unit[15:8];
        if (!page_ok[hi])
        begin
            if (pages_taken >= PAGES)
            begin
                full_seen = 1'b1;
                return;
            end
            page_ok[hi] = 1'b1;
            page_no[hi] = 5'(pages_taken);
            pages_taken++;
        end
        slot = int'(page_no[hi]) * 256 + int'(unit[7:0]);
        entry_ok[slot]  = 1'b1;
        entry_val[slot] = value;
    endfunction

    function automatic logic look_up(input logic [15:0] unit, output logic [7:0] value);
        int slot;
        value = 8'h00;
        if (!page_ok[unit[15:8]])
            return 1'b0;
        slot  = int'(page_no[unit[15:8]]) * 256 + int'(unit[7:0]);
        value = entry_val[slot];
        return entry_ok[slot];
    endfunction

    // Work out the results of one accepted request and queue them
    function automatic void predict_encoding(input stim_row_t row);
        enc_result_t res [2];
        int          n;
        logic [7:0]  mapped;
        logic        absorbed;
        n        = 0;
        absorbed = 1'b0;
        case (row.cmd)
            sbce_pkg::CMD_CLEAR:
            begin
                clear_tables();
                res[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
                n = 1;
            end
            sbce_pkg::CMD_LOAD_DECODE, sbce_pkg::CMD_LOAD_EXTRA:
            begin
                if (row.cmd == sbce_pkg::CMD_LOAD_EXTRA)
                    map_unit(row.unit, row.bval);
                else if (row.unit != sbce_pkg::UNIT_NO_CHAR)
                    map_unit(row.unit, row.bval ^ sbce_pkg::DECODE_FLIP);
                res[0] = '{8'h00, 1'b0, full_seen, 1'b0};
                n = 1;
            end
            default:
            begin
                // flush a held high surrogate; a low surrogate joins it
                if (high_held)
                begin
                    high_held = 1'b0;
                    res[n] = '{repl_byte, 1'b1, full_seen, 1'b0};
                    n++;
                    absorbed = (row.unit[15:10] == sbce_pkg::LOW_SURR_TAG);
                end
                if (!absorbed)
                begin
                    if (look_up(row.unit, mapped))
                    begin
                        res[n] = '{mapped, 1'b0, full_seen, 1'b0};
                        n++;
                    end
                    else if (row.unit[15:10] == sbce_pkg::HIGH_SURR_TAG && !row.eot)
                        high_held = 1'b1;
                    else
                    begin
                        res[n] = '{repl_byte, 1'b1, full_seen, 1'b0};
                        n++;
                    end
                end
            end
        endcase
        if (n > 0)
            res[n-1].last = 1'b1;
        if (row.typed)
            res[0] = row.res;
        for (int i = 0; i < n; i++)
            expected_results.push_back(res[i]);
    endfunction

    function automatic stim_row_t plain_row(input sbce_pkg::cmd_t cmd, input logic [7:0] bval,
                                            input logic [15:0] unit, input logic eot);
        stim_row_t row;
        row      = '0;
        row.cmd  = cmd;
        row.bval = bval;
        row.unit = unit;
        row.eot  = eot;
        return row;
    endfunction

    function automatic logic [7:0] pick_high();
        if ($urandom_range(99) < 15)
            return 8'($urandom);
        return HIGH_POOL[$urandom_range(POOL_SIZE - 1)];
    endfunction

    function automatic logic [15:0] pick_unit();
        int r;
        r = $urandom_range(99);
        if (r < 50 && mapped_units.size() > 0)
            return mapped_units[$urandom_range(mapped_units.size() - 1)];
        if (r < 65)
            return {sbce_pkg::HIGH_SURR_TAG, 10'($urandom)};
        if (r < 72)
            return {sbce_pkg::LOW_SURR_TAG, 10'($urandom)};
        if (r < 76)
            return sbce_pkg::UNIT_NO_CHAR;
        if (r < 88)
            return {pick_high(), 8'($urandom)};
        return 16'($urandom);
    endfunction

    // Offer one request after a random gap and hold it until accepted
    task automatic send_item(input stim_row_t row);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= row.cmd;
        s_tdata  <= {row.unit, row.bval};
        s_tlast  <= row.eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_encoding(row);
        if (row.cmd == sbce_pkg::CMD_CLEAR)
            mapped_units.delete();
        else if (row.cmd != sbce_pkg::CMD_ENCODE)
        begin
            mapped_units.push_back(row.unit);
            if (mapped_units.size() > KNOWN_DEPTH)
                void'(mapped_units.pop_front());
        end
        items_sent++;
    endtask

    // One run of requests: a clear, a batch of loads, a text to encode, or noise
    task automatic random_run();
        int          kind;
        int          len;
        logic [15:0] unit;
        logic        prev_high;
        kind      = $urandom_range(99);
        prev_high = 1'b0;
        if (kind < 2)
            send_item(plain_row(sbce_pkg::CMD_CLEAR, 8'($urandom), 16'($urandom),
                                1'($urandom)));
        else if (kind < 30)
        begin
            len = $urandom_range(8, 1);
            repeat (len)
            begin
                if ($urandom_range(19) == 0)
                    unit = sbce_pkg::UNIT_NO_CHAR;
                else
                    unit = {pick_high(), 8'($urandom)};
                send_item(plain_row($urandom_range(1) ? sbce_pkg::CMD_LOAD_DECODE
                                                      : sbce_pkg::CMD_LOAD_EXTRA,
                                    8'($urandom), unit, 1'($urandom)));
            end
        end
        else if (kind < 92)
        begin
            len = $urandom_range(12, 1);
            for (int i = 0; i < len; i++)
            begin
                if (prev_high && $urandom_range(1))
                    unit = {sbce_pkg::LOW_SURR_TAG, 10'($urandom)};
                else
                    unit = pick_unit();
                prev_high = (unit[15:10] == sbce_pkg::HIGH_SURR_TAG);
                send_item(plain_row(sbce_pkg::CMD_ENCODE, 8'($urandom), unit,
                                    (i == len - 1) ? ($urandom_range(3) != 0)
                                                   : ($urandom_range(19) == 0)));
            end
        end
        else
        begin
            repeat ($urandom_range(4, 1))
                send_item(plain_row(sbce_pkg::cmd_t'($urandom_range(3)), 8'($urandom),
                                    16'($urandom), 1'($urandom)));
        end
    endtask

    // Leave the bus in the access phase; the caller closes it
    task automatic apb_access(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {sbce_pkg::REG_REPLACEMENT, 2'b00};
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        rdata = prdata;
    endtask

    task automatic set_replacement(input logic [7:0] value);
        logic [31:0] readback;
        apb_access(1'b1, {24'h0, value}, readback);
        repl_byte = value;
        apb_access(1'b0, 32'h0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {24'h0, value})
            report_mismatch("replacement readback", readback, {24'h0, value});
    endtask

    // Stop offering and wait until every expected result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Receiver: random stalls, or a long hold-off when asked
    initial
    begin : receiver
        int hold_left;
        int hold_seen;
        hold_left = 0;
        hold_seen = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_asks != hold_seen)
            begin
                hold_seen = hold_asks;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin : result_check
        enc_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing expected", 32'(m_tdata), 32'h0);
            else
            begin
                want = expected_results.pop_front();
                if (m_tdata[7:0] !== want.code_byte)
                    report_mismatch("out_byte", 32'(m_tdata[7:0]), 32'(want.code_byte));
                if (m_tdata[8] !== want.full)
                    report_mismatch("table_full", 32'(m_tdata[8]), 32'(want.full));
                if (m_tdata[15:9] !== 7'h00)
                    report_mismatch("tdata padding", 32'(m_tdata[15:9]), 32'h0);
                if (m_tuser[0] !== want.unmapped)
                    report_mismatch("unmappable", 32'(m_tuser[0]), 32'(want.unmapped));
                if (m_tlast !== want.last)
                    report_mismatch("last", 32'(m_tlast), 32'(want.last));
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("single_byte_charset_encoder: mismatch");
        $finish;
    end

    initial
    begin : stimulus
        logic [31:0] readback;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = '0;
        s_tlast        = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        rst_n          = 1'b0;
        hold_asks      = 0;
        items_sent     = 0;
        mismatch_count = 0;
        send_idle_pct  = 11;
        recv_idle_pct  = 62;
        clear_tables();
        repl_byte = sbce_pkg::REPL_RESET;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset value is readable during the clearing pass
        apb_access(1'b0, 32'h0, readback);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (readback !== {24'h0, sbce_pkg::REPL_RESET})
            report_mismatch("replacement after reset", readback,
                            {24'h0, sbce_pkg::REPL_RESET});

        for (int i = 0; i < DIRECTED_ROWS; i++)
            send_item(DIRECTED_PLAN[i]);
        drain();

        // Sender rarely idle, receiver often stalled
        set_replacement(8'hFF);
        items_sent = 0;
        while (items_sent < RANDOM_ITEMS / 3)
            random_run();
        drain();

        // Sender often idle, receiver rarely stalled
        set_replacement(8'h00);
        send_idle_pct = 62;
        recv_idle_pct = 11;
        while (items_sent < 2 * RANDOM_ITEMS / 3)
            random_run();
        drain();

        // No idling; start with a long receiver hold-off to back up the input
        set_replacement(8'($urandom));
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asks++;
        repeat (40)
            send_item(plain_row(sbce_pkg::CMD_ENCODE, 8'($urandom), pick_unit(), 1'b0));
        while (items_sent < RANDOM_ITEMS)
            random_run();
        drain();

        if (mismatch_count == 0)
            $display("single_byte_charset_encoder: match");
        else
            $display("single_byte_charset_encoder: mismatch");
        $finish;
    end

endmodule

// ===== single_byte_charset_encoder.f =====
rtl/core/sbce_pkg.sv
rtl/core/sbce_datapath.sv
rtl/core/sbce_ctrl.sv
rtl/core/single_byte_charset_encoder.sv
verif/single_byte_charset_encoder_tb.sv
